FILE: sv/kar_pkg.sv
// Package for the accelerating key auto-repeat block.
// Holds the sequencer state type, register indexes and fixed arithmetic constants.
// No dependencies.
package kar_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_TERM,
    ST_ACCEL,
    ST_INT_DIV,
    ST_WRITE
  } kar_state_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL     = 1'd1;

  // Field widths
  localparam int CODE_W  = 8;
  localparam int TIME_W  = 40;
  localparam int CFG_W   = 16;

  // Register reset values
  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd500;
  localparam logic [CFG_W-1:0] ACCEL_RESET = 16'd1280;

  // Divider: 24-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 16;
  localparam int CNT_W      = 5;
  localparam int DIV_STEPS  = DIVIDEND_W;

  // Acceleration arithmetic (Q8.8)
  localparam logic [DIVISOR_W-1:0] ACCEL_ONE   = 16'd256;
  localparam logic [DIVISOR_W-1:0] TERM_MAX    = 16'hFFFF;
  // hold*256/500 == hold*64/125 == (hold * 8589935) >> 24, exact for hold < 2^17
  localparam int HOLD_W     = 17;
  localparam int RECIP_W    = 24;
  localparam int TERM_SHIFT = 24;
  localparam int PROD_W     = TERM_SHIFT + DIVISOR_W;
  localparam logic [RECIP_W-1:0] TERM_RECIP = 24'd8589935;
  // term saturates once hold*64/125 reaches 65536, i.e. hold >= 128000
  localparam logic [TIME_W-1:0] HOLD_SAT = 40'd128000;

endpackage

FILE: sv/kar_ram.sv
// Generic simple dual-port RAM with registered read data.
// One write port, one read port, no reset on contents. No dependencies.
module kar_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/key_autorepeat_accelerating.sv
// Top level of the accelerating key auto-repeat block.
// Depends on kar_pkg and kar_ram (per-key first-press / next-allowed times).
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------------------------
//   input     start & !busy        in_vkey, in_key_down, in_time_ms
//   result    out_valid (1 cycle)  out_pressed
//   config    cfg_we               cfg_index, cfg_wdata
//
// Each accepted word gives exactly one result word. Key code zero, out-of-range
// codes, releases and fresh presses finish in ST_LOOKUP; a held key polled too
// early finishes in ST_CHECK; a due repeat runs through ST_TERM (skipped when
// the hold term saturates), ST_ACCEL, the restoring divider's 24 steps and ST_WRITE.
// The result strobe follows the last sequencer cycle; busy drops with it.
// Reset clears the held flags at once; the time table needs no clearing pass.
// The receiver cannot stall, so no result is ever held back.
module key_autorepeat_accelerating
  import kar_pkg::*;
#(
  parameter int NUM_KEYS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CODE_W-1:0]    in_vkey,
  input  logic                 in_key_down,
  input  logic [TIME_W-1:0]    in_time_ms,
  output logic                 out_valid,
  output logic                 out_pressed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Only codes below 2^CODE_W can ever be polled
  localparam int KEY_DEPTH = (NUM_KEYS < (1 << CODE_W)) ? NUM_KEYS : (1 << CODE_W);
  localparam int ADDR_W    = $clog2(KEY_DEPTH);
  localparam int LIMIT_W   = $clog2(NUM_KEYS + 1);
  localparam int CMP_W     = (LIMIT_W > CODE_W) ? LIMIT_W : CODE_W;
  localparam logic [CMP_W-1:0] KEY_LIMIT = CMP_W'(NUM_KEYS);
  localparam int ENTRY_W   = 2 * TIME_W;

  kar_state_t state_r, state_nxt;

  logic [CFG_W-1:0]       delay_r;
  logic [CFG_W-1:0]       accel_max_r;
  logic [CODE_W-1:0]      code_r;
  logic                   down_r;
  logic [TIME_W-1:0]      now_r;
  logic [KEY_DEPTH-1:0]   held_r;
  logic [TIME_W-1:0]      first_r;
  logic [HOLD_W-1:0]      hold_r;
  logic [DIVISOR_W-1:0]   term_r;
  logic [DIVIDEND_W-1:0]  div_quo_r;
  logic [DIVISOR_W-1:0]   div_rem_r;
  logic [DIVISOR_W-1:0]   div_den_r;
  logic [CNT_W-1:0]       div_cnt_r;
  logic                   out_valid_r;
  logic                   out_pressed_r;

  // Decode and datapath
  logic [ADDR_W-1:0]      key_idx;
  logic                   code_ok;
  logic                   held_bit;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [TIME_W-1:0]      rd_first;
  logic [TIME_W-1:0]      rd_next;
  logic                   too_early;
  logic [TIME_W-1:0]      hold;
  logic                   hold_sat;
  logic [PROD_W-1:0]      term_prod;
  logic [DIVISOR_W-1:0]   ceiling;
  logic [DIVISOR_W:0]     accel_sum;
  logic [DIVISOR_W-1:0]   accel;
  logic [DIVISOR_W:0]     div_trial;
  logic                   div_ge;
  logic [DIVISOR_W-1:0]   div_rem_nxt;
  logic [DIVIDEND_W-1:0]  div_quo_nxt;
  logic                   div_last;

  // Sequencer outputs
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic                   emit;
  logic                   emit_pressed;
  logic                   held_set;
  logic                   held_clr;
  logic                   div_load;
  logic                   div_step;
  logic [DIVIDEND_W-1:0]  div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   hold_load;
  logic                   term_load_sat;
  logic                   term_load_mul;

  assign key_idx   = code_r[ADDR_W-1:0];
  assign code_ok   = (code_r != '0) && (CMP_W'(code_r) < KEY_LIMIT);
  assign held_bit  = held_r[key_idx];
  assign rd_first  = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_next   = ram_rdata[TIME_W-1:0];
  assign too_early = now_r < rd_next;
  assign hold      = now_r - rd_first;
  assign hold_sat  = hold >= HOLD_SAT;

  // Hold term by reciprocal multiply: hold*64/125 for hold below the saturation point
  assign term_prod = PROD_W'(hold_r) * PROD_W'(TERM_RECIP);

  // Clamp a zero ceiling to one, then take min(1.0 + term, ceiling)
  assign ceiling   = (accel_max_r == '0) ? DIVISOR_W'(1) : accel_max_r;
  assign accel_sum = {1'b0, ACCEL_ONE} + {1'b0, term_r};
  assign accel     = (accel_sum > {1'b0, ceiling}) ? ceiling : accel_sum[DIVISOR_W-1:0];

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  assign div_trial   = {div_rem_r, div_quo_r[DIVIDEND_W-1]};
  assign div_ge      = div_trial >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? DIVISOR_W'(div_trial - {1'b0, div_den_r})
                              : div_trial[DIVISOR_W-1:0];
  assign div_quo_nxt = {div_quo_r[DIVIDEND_W-2:0], div_ge};
  assign div_last    = div_cnt_r == CNT_W'(DIV_STEPS - 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (code_ok && down_r && held_bit) begin
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        priority if (too_early) begin
          state_nxt = ST_IDLE;
        end else if (hold_sat) begin
          state_nxt = ST_ACCEL;
        end else begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM:    state_nxt = ST_ACCEL;
      ST_ACCEL:   state_nxt = ST_INT_DIV;
      ST_INT_DIV: begin
        if (div_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE:   state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ram_we        = 1'b0;
    ram_wdata     = {first_r, now_r + TIME_W'(div_quo_r)};
    ram_re        = 1'b0;
    emit          = 1'b0;
    emit_pressed  = 1'b0;
    held_set      = 1'b0;
    held_clr      = 1'b0;
    div_load      = 1'b0;
    div_step      = 1'b0;
    div_dividend  = {delay_r, 8'b0};
    div_divisor   = accel;
    hold_load     = 1'b0;
    term_load_sat = 1'b0;
    term_load_mul = 1'b0;
    unique case (state_r)
      ST_LOOKUP: begin
        priority if (!code_ok) begin
          emit = 1'b1;
        end else if (!down_r) begin
          held_clr = 1'b1;
          emit     = 1'b1;
        end else if (!held_bit) begin
          // fresh press: arm the first repeat after the initial delay
          held_set     = 1'b1;
          ram_we       = 1'b1;
          ram_wdata    = {now_r, now_r + TIME_W'(delay_r)};
          emit         = 1'b1;
          emit_pressed = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_CHECK: begin
        priority if (too_early) begin
          emit = 1'b1;
        end else if (hold_sat) begin
          term_load_sat = 1'b1;
        end else begin
          // hold < 128000 here, so it fits the multiplier input
          hold_load = 1'b1;
        end
      end
      ST_TERM: begin
        term_load_mul = 1'b1;
      end
      ST_ACCEL: begin
        // interval = delay*256/accel
        div_load = 1'b1;
      end
      ST_INT_DIV: begin
        div_step = 1'b1;
      end
      ST_WRITE: begin
        ram_we       = 1'b1;
        emit         = 1'b1;
        emit_pressed = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      delay_r       <= DELAY_RESET;
      accel_max_r   <= ACCEL_RESET;
      held_r        <= '0;
      out_valid_r   <= 1'b0;
      out_pressed_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= emit;
      out_pressed_r <= emit_pressed;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INITIAL_DELAY: delay_r     <= cfg_wdata;
          CFG_MAX_ACCEL:     accel_max_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (held_set) begin
        held_r[key_idx] <= 1'b1;
      end else if (held_clr) begin
        held_r[key_idx] <= 1'b0;
      end
    end
  end

  // Capture the polled word, the stored first-press time, the hold and its term
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      code_r <= in_vkey;
      down_r <= in_key_down;
      now_r  <= in_time_ms;
    end
    if (state_r == ST_CHECK) begin
      first_r <= rd_first;
    end
    if (hold_load) begin
      hold_r <= hold[HOLD_W-1:0];
    end
    if (term_load_sat) begin
      term_r <= TERM_MAX;
    end else if (term_load_mul) begin
      term_r <= term_prod[PROD_W-1:TERM_SHIFT];
    end
  end

  // Divider: load, then advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_load) begin
      div_cnt_r <= '0;
    end else if (div_step) begin
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_quo_r <= div_dividend;
      div_rem_r <= '0;
      div_den_r <= div_divisor;
    end else if (div_step) begin
      div_quo_r <= div_quo_nxt;
      div_rem_r <= div_rem_nxt;
    end
  end

  // Per-key time table: {first_press_time, next_allowed_time}
  kar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_DEPTH)
  ) u_time_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (key_idx),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (key_idx),
    .rd_data (ram_rdata)
  );

  assign busy        = state_r != ST_IDLE;
  assign out_valid   = out_valid_r;
  assign out_pressed = out_pressed_r;

  // A result word only follows a working cycle of the sequencer
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a preceding working cycle");

  // Key code zero gives a not-pressed word, registered from the lookup state after acceptance
  a_code_zero_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_vkey == '0) |=> ##1 (out_valid && !out_pressed))
    else $error("key code zero did not give a single not-pressed word");

  // The interval divide never runs on a zero acceleration
  a_accel_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INT_DIV) |-> (div_den_r != '0))
    else $error("interval divide with zero divisor");

endmodule

FILE: verif/kar_checker.sv
// Result checker for the accelerating key auto-repeat block.
// Tracks the per-key repeat table and registers, predicts each pressed flag, compares results.
// Depends on kar_pkg.
module kar_checker
  import kar_pkg::*;
#(
  parameter int NUM_KEYS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CODE_W-1:0]    vkey,
  input  logic                 key_down,
  input  logic [TIME_W-1:0]    time_ms,
  input  logic                 out_valid,
  input  logic                 out_pressed,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending_words,
  output int                   polls_seen,
  output int                   presses_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q8.8 acceleration arithmetic
  localparam logic [63:0] HOLD_SCALE = 64'd256;
  localparam logic [63:0] HOLD_DIV   = 64'd500;
  localparam logic [63:0] TERM_CEIL  = 64'd65535;
  localparam logic [31:0] UNITY_Q8   = 32'd256;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] stamp;
    logic              pressed;
  } poll_rec_t;

  // Per-key repeat table and register copies
  logic              held_tbl  [NUM_KEYS];
  logic [TIME_W-1:0] first_tbl [NUM_KEYS];
  logic [TIME_W-1:0] due_tbl   [NUM_KEYS];
  logic [CFG_W-1:0]  delay_ms;
  logic [CFG_W-1:0]  accel_cap;

  poll_rec_t pressed_q[$];
  int        err_n   = 0;
  int        poll_n  = 0;
  int        press_n = 0;

  // Update the key's entry for one poll and return the pressed flag it earns
  function automatic logic poll_key(input logic [CODE_W-1:0] code, input logic down,
                                    input logic [TIME_W-1:0] now);
    int unsigned       k;
    logic [TIME_W-1:0] hold;
    logic [63:0]       term;
    logic [31:0]       accel;
    logic [31:0]       cap;
    logic [31:0]       gap;
    k = code;
    if (code == '0 || k >= NUM_KEYS) return 1'b0;
    if (!down) begin
      held_tbl[k]  = 1'b0;
      first_tbl[k] = '0;
      due_tbl[k]   = '0;
      return 1'b0;
    end
    if (!held_tbl[k]) begin
      held_tbl[k]  = 1'b1;
      first_tbl[k] = now;
      due_tbl[k]   = now + TIME_W'(delay_ms);
      return 1'b1;
    end
    if (now < due_tbl[k]) return 1'b0;
    // Hold time wraps at 40 bits; a huge hold just saturates the term
    hold = now - first_tbl[k];
    term = 64'(hold) * HOLD_SCALE / HOLD_DIV;
    if (term > TERM_CEIL) term = TERM_CEIL;
    cap = (accel_cap == '0) ? 32'd1 : 32'(accel_cap);
    accel = UNITY_Q8 + term[31:0];
    if (accel > cap) accel = cap;
    gap = 32'(delay_ms) * UNITY_Q8 / accel;
    due_tbl[k] = now + TIME_W'(gap);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    poll_rec_t rec;
    if (!rst_n) begin
      // Clear the table and restore register defaults
      for (int i = 0; i < NUM_KEYS; i++) begin
        held_tbl[i]  = 1'b0;
        first_tbl[i] = '0;
        due_tbl[i]   = '0;
      end
      delay_ms  = DELAY_RESET;
      accel_cap = ACCEL_RESET;
      pressed_q.delete();
    end else begin
      // Compare a result word with the oldest prediction
      if (out_valid) begin
        if (pressed_q.size() == 0) begin
          err_n++;
          $display("%0t: result word pressed=%0b with no poll waiting", $time, out_pressed);
        end else begin
          rec = pressed_q.pop_front();
          if (out_pressed === 1'b1) press_n++;
          if (out_pressed !== rec.pressed) begin
            err_n++;
            $display("%0t: key %0d at %0d ms: expected pressed=%0b, actual %0b",
                     $time, rec.code, rec.stamp, rec.pressed, out_pressed);
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_DELAY: delay_ms = cfg_wdata;
          CFG_MAX_ACCEL:     accel_cap = cfg_wdata;
          default: ;
        endcase
      end
      // Predict each accepted poll
      if (start && !busy) begin
        rec.code    = vkey;
        rec.stamp   = time_ms;
        rec.pressed = poll_key(vkey, key_down, time_ms);
        pressed_q.push_back(rec);
        poll_n++;
      end
    end
    fail_count    <= err_n;
    pending_words <= pressed_q.size();
    polls_seen    <= poll_n;
    presses_seen  <= press_n;
  end

endmodule

FILE: verif/tb_top.sv
// Top of the testbench for the accelerating key auto-repeat block.
// Drives polls in bursts and register settings, and gives the verdict from kar_checker.
// Depends on kar_pkg, kar_checker and key_autorepeat_accelerating.
module tb_top
  import kar_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                NUM_KEYS     = 256;
  localparam int                POLLS_PER_SET = 148;
  localparam int                NUM_SETS     = 9;
  localparam logic [TIME_W-1:0] MAX_TIME     = '1;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic [CODE_W-1:0]    in_vkey     = '0;
  logic                 in_key_down = 1'b0;
  logic [TIME_W-1:0]    in_time_ms  = '0;
  logic                 out_valid;
  logic                 out_pressed;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_INITIAL_DELAY;
  logic [CFG_W-1:0]     cfg_wdata   = '0;

  int fail_count;
  int pending_words;
  int polls_seen;
  int presses_seen;

  logic [TIME_W-1:0] clock_ms = '0;
  logic [CFG_W-1:0]  cur_delay = DELAY_RESET;
  logic [CODE_W-1:0] key_pool [4];
  int                settings_used = 1;

  key_autorepeat_accelerating #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vkey(in_vkey), .in_key_down(in_key_down), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_pressed(out_pressed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  kar_checker #(.NUM_KEYS(NUM_KEYS)) u_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .vkey(in_vkey), .key_down(in_key_down), .time_ms(in_time_ms),
    .out_valid(out_valid), .out_pressed(out_pressed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_words(pending_words),
    .polls_seen(polls_seen), .presses_seen(presses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Offer one poll word and hold it until accepted; keep start high if more follow
  task automatic send_word(input logic [CODE_W-1:0] code, input logic down,
                           input logic [TIME_W-1:0] stamp, input bit keep);
    in_vkey     <= code;
    in_key_down <= down;
    in_time_ms  <= stamp;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    if (!keep) start <= 1'b0;
  endtask

  // Wait until every predicted word has come back, then let the block settle
  task automatic drain_all();
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on back-to-back cycles
  task automatic set_regs(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] accel);
    cfg_index <= CFG_INITIAL_DELAY;
    cfg_wdata <= delay;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_index <= CFG_MAX_ACCEL;
    cfg_wdata <= accel;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cur_delay = delay;
    settings_used++;
  endtask

  // Advance the poll time: mostly small steps, sometimes long holds, backsteps and wraps
  function automatic void step_clock();
    int          sel;
    logic [63:0] r;
    sel = $urandom_range(0, 99);
    r   = {$urandom, $urandom};
    if (sel < 55)
      clock_ms = clock_ms + TIME_W'($urandom_range(0, cur_delay / 3 + 8));
    else if (sel < 77)
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * cur_delay + 8));
    else if (sel < 84)
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 300000));
    else if (sel < 88)
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 256 * cur_delay + 8));
    else if (sel < 91)
      clock_ms = clock_ms - TIME_W'($urandom_range(1, 5000));
    else if (sel < 94)
      clock_ms = MAX_TIME - TIME_W'($urandom_range(0, 2 * cur_delay + 10));
    else if (sel < 96)
      clock_ms = r[TIME_W-1:0];
  endfunction

  // Random polls, mostly on a small pool of keys, sent in bursts with gaps
  task automatic run_setting(input int n);
    int                burst_left;
    int                sel;
    bit                keep;
    logic [CODE_W-1:0] code;
    logic              down;
    for (int k = 0; k < 4; k++) key_pool[k] = CODE_W'($urandom_range(1, 255));
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75)
        code = key_pool[$urandom_range(0, 3)];
      else if (sel < 85)
        code = '0;
      else
        code = CODE_W'($urandom_range(0, 255));
      down = ($urandom_range(0, 99) < 88);
      step_clock();
      keep = (burst_left > 1) && (i != n - 1);
      send_word(code, down, clock_ms, keep);
      burst_left--;
      if (!keep && i != n - 1) begin
        // Idle gap between bursts, or now and then a full drain
        if ($urandom_range(0, 9) == 0)
          drain_all();
        else
          repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
      end
    end
    drain_all();
  endtask

  initial begin
    logic [CFG_W-1:0] d;
    logic [CFG_W-1:0] a;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls under reset register values
    send_word(8'd0,   1'b1, 40'd0, 1);
    send_word(8'd0,   1'b0, 40'd0, 1);
    send_word(8'd255, 1'b1, 40'd0, 1);
    send_word(8'd255, 1'b1, 40'd100, 1);
    send_word(8'd255, 1'b1, 40'd500, 1);
    send_word(8'd255, 1'b1, 40'd749, 1);
    send_word(8'd255, 1'b1, 40'd750, 1);
    send_word(8'd255, 1'b1, 40'd200000, 1);
    send_word(8'd255, 1'b0, 40'd200001, 1);
    send_word(8'd255, 1'b0, 40'd200002, 1);
    // Press near the top of the time range: next time wraps and is met at once
    send_word(8'd1,   1'b1, MAX_TIME - 40'd99, 1);
    send_word(8'd1,   1'b1, MAX_TIME - 40'd98, 1);
    send_word(8'd1,   1'b1, 40'd3, 1);
    send_word(8'd1,   1'b1, 40'd401, 1);
    // Time far behind the first press gives a saturated hold term
    send_word(8'd3,   1'b1, MAX_TIME - 40'd10, 1);
    send_word(8'd3,   1'b1, 40'h80_0000_0000, 1);
    send_word(8'd170, 1'b1, 40'h55_5555_5555, 1);
    send_word(8'd85,  1'b1, 40'hAA_AAAA_AAAA, 1);
    send_word(8'd170, 1'b1, 40'h55_5555_5554, 1);
    send_word(8'd255, 1'b1, MAX_TIME, 1);
    send_word(8'd255, 1'b1, MAX_TIME, 1);
    send_word(8'd1,   1'b0, 40'd0, 0);
    drain_all();

    // Random polls over a series of register settings, extremes included
    for (int s = 0; s < NUM_SETS; s++) begin
      if (s > 0) begin
        case (s)
          1: begin d = 16'd65535; a = 16'd65535; end
          2: begin d = 16'd0;     a = 16'd1;     end
          3: begin d = 16'd20;    a = 16'd0;     end
          4: begin d = 16'd3;     a = 16'd1;     end
          5: begin
            d = CFG_W'($urandom_range(0, 2000));
            a = CFG_W'($urandom_range(0, 65535));
          end
          6: begin d = 16'd65535; a = 16'd256;   end
          7: begin d = 16'd100;   a = 16'd65535; end
          default: begin
            d = CFG_W'($urandom_range(0, 65535));
            a = CFG_W'($urandom_range(1, 3000));
          end
        endcase
        set_regs(d, a);
      end
      run_setting(POLLS_PER_SET);
    end

    // Catch any stray result words
    repeat (60) @(posedge clk);
    $display("summary: %0d polls under %0d register settings, %0d reported pressed",
             polls_seen, settings_used, presses_seen);
    if (fail_count == 0 && pending_words == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: sim.f
sv/kar_pkg.sv
sv/kar_ram.sv
sv/key_autorepeat_accelerating.sv
verif/kar_checker.sv
verif/tb_top.sv
